### rtl/core/gpt_pkg.sv
// Package for the growing prime table: sizes, action and status codes,
// controller state type. No dependencies.
package gpt_pkg;
   localparam int VALUE_BITS_DEF  = 16;
   localparam int TABLE_DEPTH_DEF = 8192;

   typedef enum logic [1:0] {
      ACT_NEXT   = 2'd0,
      ACT_READ   = 2'd1,
      ACT_EXTEND = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_INDEX = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH,
      S_SRCH_WAIT,
      S_CAND,
      S_DIV_RD,
      S_DIV_WAIT,
      S_DIV_RUN,
      S_APPEND,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch request
      logic srch_init;   // start binary search
      logic srch_rd;     // read midpoint
      logic srch_step;   // narrow search
      logic cand_init;   // candidate = largest + 1
      logic cand_next;   // candidate++
      logic trial_init;  // k = 0
      logic trial_rd;    // read entry k
      logic div_start;   // start remainder unit
      logic div_step;    // one remainder bit
      logic trial_next;  // k++
      logic append;      // write candidate
      logic rd_index;    // read entry at value
      logic fin;         // build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic srch_done;
      logic below_largest;
      logic cand_over;   // candidate past limit
      logic cand_range;  // candidate past value range
      logic trial_end;   // all stored primes used or p*p > c
      logic div_done;
      logic divisible;
      logic full;
   } sts_type;
endpackage

### rtl/core/growing_prime_table_top.sv
// Growing prime table: ascending table of all primes up to its largest
// entry, seeded with 2 at reset.
//
// Channels: req_ (action, value) and rsp_ (prime, stored_count,
// largest_prime, status), both valid/ready. One response per request.
// Action 0 gives the next prime above value (binary search when value is
// below the largest entry, else the table grows), action 1 reads the entry
// at an index, action 2 grows the table to cover value.
// Growth tests each candidate by trial division with a bit-serial
// remainder unit, trying each stored prime up to sqrt of the candidate.
// One request is worked on at a time; a new request is taken from the
// cycle after the response has been accepted.
// Reset: the table holds only 2, count 1, no response pending.
// Stall: a response holds while rsp_ready is low and no request is taken.
module growing_prime_table_top #(
   parameter int VALUE_BITS  = gpt_pkg::VALUE_BITS_DEF,
   parameter int TABLE_DEPTH = gpt_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_prime,
   output logic [13:0] rsp_stored_count,
   output logic [15:0] rsp_largest_prime,
   output logic [1:0]  rsp_status
);
   import gpt_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   action_type act;
   status_type status;

   gpt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .act, .rsp_valid, .rsp_ready,
      .sts, .cmd, .status
   );

   gpt_dp #(.VALUE_BITS(VALUE_BITS), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .req_action, .req_value, .cmd, .status, .sts, .act,
      .rsp_prime, .rsp_stored_count, .rsp_largest_prime, .rsp_status
   );
endmodule

### rtl/core/gpt_ctrl.sv
// Controller state machine of the growing prime table.
// Depends on gpt_pkg.
module gpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gpt_pkg::action_type act,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  gpt_pkg::sts_type  sts,
   output gpt_pkg::cmd_type  cmd,
   output gpt_pkg::status_type status
);
   import gpt_pkg::*;

   state_type  state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       phase_ff, phase_in;   // 0 grow to value, 1 find next above
   logic       stfull_ff, stfull_in;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign status    = stfull_ff ? ST_FULL : ST_OK;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      stfull_in = stfull_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               state_in  = S_DECODE;
               phase_in  = 1'b0;
               stfull_in = 1'b0;
            end
         end
         S_DECODE: begin
            case (act)
               ACT_NEXT:   state_in = sts.below_largest ? S_SRCH : S_CAND;
               ACT_EXTEND: state_in = S_CAND;
               default:    state_in = S_DONE;
            endcase
         end
         S_SRCH:      state_in = sts.srch_done ? S_DONE : S_SRCH_WAIT;
         S_SRCH_WAIT: state_in = S_SRCH;
         S_CAND: begin
            if (!phase_ff && sts.cand_over) begin
               if (act == ACT_NEXT) phase_in = 1'b1;
               else state_in = S_DONE;
            end else if (phase_ff && sts.cand_range) begin
               stfull_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in = S_DIV_RD;
            end
         end
         S_DIV_RD:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: state_in = sts.trial_end ? S_APPEND : S_DIV_RUN;
         S_DIV_RUN: begin
            if (sts.div_done) state_in = sts.divisible ? S_CAND : S_DIV_RD;
         end
         S_APPEND: begin
            if (sts.full) begin
               stfull_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               state_in = phase_ff ? S_DONE : S_CAND;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      rv_in = rv_ff && !rsp_ready;
      case (state_ff)
         S_IDLE:   cmd.load = req_valid && req_ready;
         S_DECODE: begin
            cmd.srch_init = 1'b1;
            cmd.cand_init = 1'b1;
            cmd.rd_index  = 1'b1;
         end
         S_SRCH:      cmd.srch_rd = 1'b1;   // midpoint equals lo once done
         S_SRCH_WAIT: cmd.srch_step = 1'b1;
         S_CAND:      cmd.trial_init = 1'b1;
         S_DIV_RD:    cmd.trial_rd = 1'b1;
         S_DIV_WAIT:  cmd.div_start = !sts.trial_end;
         S_DIV_RUN: begin
            cmd.div_step = !sts.div_done;
            cmd.cand_next  = sts.div_done && sts.divisible;
            cmd.trial_next = sts.div_done && !sts.divisible;
         end
         S_APPEND: begin
            cmd.append    = !sts.full;
            cmd.cand_next = !sts.full && !phase_ff;
         end
         S_DONE: begin
            cmd.fin = 1'b1;
            rv_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rv_ff     <= 1'b0;
         phase_ff  <= 1'b0;
         stfull_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         phase_ff  <= phase_in;
         stfull_ff <= stfull_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid) else $error("no result after done");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE)) else $error("result while working");
endmodule

### rtl/core/gpt_dp.sv
// Datapath of the growing prime table: prime store memory, binary search,
// candidate trial division by a bit-serial remainder unit. Depends on gpt_pkg.
module gpt_dp #(
   parameter int VALUE_BITS  = gpt_pkg::VALUE_BITS_DEF,
   parameter int TABLE_DEPTH = gpt_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_action,
   input  logic [15:0]       req_value,
   input  gpt_pkg::cmd_type  cmd,
   input  gpt_pkg::status_type status,
   output gpt_pkg::sts_type  sts,
   output gpt_pkg::action_type act,
   output logic [15:0]       rsp_prime,
   output logic [13:0]       rsp_stored_count,
   output logic [15:0]       rsp_largest_prime,
   output logic [1:0]        rsp_status
);
   import gpt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int VW = (VALUE_BITS < 16) ? VALUE_BITS : 16;
   localparam int DW = VALUE_BITS + 1;   // candidate with overflow bit
   localparam int SW = $clog2(VALUE_BITS + 1);
   localparam int QW = 2 * VALUE_BITS;

   logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] rd_ff;
   logic [AW-1:0]         ra;

   action_type            act_ff;
   logic [VALUE_BITS-1:0] v_ff;
   logic [CW-1:0]         total_ff;
   logic [VALUE_BITS-1:0] larg_ff;
   logic [CW-1:0]         lo_ff, hi_ff, mid;
   logic [DW-1:0]         cand_ff;
   logic [CW-1:0]         k_ff;
   logic [QW-1:0]         sq, bound;
   logic [VALUE_BITS-1:0] rem_ff, div_ff;
   logic [VALUE_BITS-1:0] sh_ff;
   logic [SW-1:0]         cnt_ff;
   logic [VALUE_BITS:0]   trem;
   logic [15:0]           prime_ff;
   logic [1:0]            stat_ff;
   logic                  idx_ok;

   // memory read with entry 0 forced to 2 (the constant seed)
   function automatic logic [VALUE_BITS-1:0] rd0(input logic [CW-1:0] a);
      rd0 = (a[AW-1:0] == '0) ? VALUE_BITS'(2) : rd_ff;
   endfunction

   assign act = act_ff;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_ok = {{(32-VALUE_BITS){1'b0}}, v_ff} < {{(32-CW){1'b0}}, total_ff};

   always_comb begin
      ra = k_ff[AW-1:0];
      if (cmd.srch_rd) ra = mid[AW-1:0];
      else if (cmd.rd_index || cmd.fin) ra = v_ff[AW-1:0];
      if (cmd.srch_init) ra = v_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.append) mem[total_ff[AW-1:0]] <= cand_ff[VALUE_BITS-1:0];
      rd_ff <= mem[ra];
   end

   assign sq    = rd_ff * rd_ff;
   assign bound = (k_ff == '0) ? QW'(4) : sq;
   assign trem  = {rem_ff, sh_ff[VALUE_BITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CW'(1);
         larg_ff  <= VALUE_BITS'(2);
      end else if (cmd.append) begin
         total_ff <= total_ff + 1'b1;
         larg_ff  <= cand_ff[VALUE_BITS-1:0];
      end
   end

   // entry 0 is never written; rd0 supplies the seed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action_type'(req_action);
         v_ff   <= VALUE_BITS'(req_value[VW-1:0]);
      end
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= total_ff;
      end else if (cmd.srch_step) begin
         if (rd0(mid) > v_ff) hi_ff <= mid;
         else lo_ff <= mid + 1'b1;
      end
      if (cmd.cand_init) cand_ff <= {1'b0, larg_ff} + 1'b1;
      else if (cmd.cand_next) cand_ff <= cand_ff + 1'b1;
      if (cmd.trial_init) k_ff <= '0;
      else if (cmd.trial_next) k_ff <= k_ff + 1'b1;
      if (cmd.div_start || cmd.trial_rd) begin
         rem_ff <= '0;
         sh_ff  <= cand_ff[VALUE_BITS-1:0];
         div_ff <= rd0(k_ff);
         cnt_ff <= SW'(VALUE_BITS);
      end else if (cmd.div_step) begin
         if (trem >= {1'b0, div_ff}) rem_ff <= VALUE_BITS'(trem - {1'b0, div_ff});
         else rem_ff <= trem[VALUE_BITS-1:0];
         sh_ff  <= sh_ff << 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.fin) begin
         stat_ff <= ST_OK;
         prime_ff <= '0;
         case (act_ff)
            ACT_NEXT: begin
               if (status == ST_FULL) stat_ff <= ST_FULL;
               else if (!sts.below_largest || cand_ff[VALUE_BITS-1:0] == larg_ff)
                  prime_ff <= 16'(larg_ff);
               else prime_ff <= 16'(rd0(lo_ff));
            end
            ACT_READ: begin
               if (idx_ok) prime_ff <= 16'(rd0({1'b0, v_ff[AW-1:0]}));
               else stat_ff <= ST_INDEX;
            end
            ACT_EXTEND: begin
               stat_ff  <= status;
               prime_ff <= 16'(larg_ff);
            end
            default: ;
         endcase
      end
   end

   assign sts.srch_done     = !(lo_ff < hi_ff);
   assign sts.below_largest = v_ff < larg_ff;
   assign sts.cand_over     = cand_ff > {1'b0, v_ff};
   assign sts.cand_range    = cand_ff[VALUE_BITS];
   assign sts.trial_end     = (k_ff >= total_ff) || (bound > QW'(cand_ff));
   assign sts.div_done      = cnt_ff == '0;
   assign sts.divisible     = rem_ff == '0;
   assign sts.full          = total_ff >= CW'(TABLE_DEPTH);

   assign rsp_prime         = prime_ff;
   assign rsp_stored_count  = 14'(total_ff);
   assign rsp_largest_prime = 16'(larg_ff);
   assign rsp_status        = stat_ff;

   a_total_nz: assert property (@(posedge clock) disable iff (reset)
      total_ff != '0) else $error("empty table");
   a_total_max: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(TABLE_DEPTH)) else $error("table overrun");
   a_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> total_ff == $past(total_ff) + 1'b1) else $error("bad append");
endmodule

### tb/sv/tb_growing_prime_table_top.sv
// Testbench for growing_prime_table_top: directed table then random requests,
// checked against typed answers or a bench prime table model. Needs gpt_pkg.
`timescale 1ns / 100ps

module tb_growing_prime_table_top;
   import gpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20_000_000;
   localparam int LONG_HOLD      = 300;

   typedef struct {
      logic [15:0] prime;
      logic [13:0] count;
      logic [15:0] largest;
      status_type  status;
   } answer_type;

   typedef struct {
      action_type  act;
      logic [15:0] val;
      bit          typed;
      answer_type  ans;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [15:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_prime;
   logic [13:0] rsp_stored_count;
   logic [15:0] rsp_largest_prime;
   logic [1:0]  rsp_status;

   growing_prime_table_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prime(rsp_prime), .rsp_stored_count(rsp_stored_count),
      .rsp_largest_prime(rsp_largest_prime), .rsp_status(rsp_status)
   );

   // bench copy of the prime table
   int unsigned primes [TABLE_DEPTH_DEF];
   int unsigned prime_cnt;

   answer_type  answer_q[$];
   int          req_accepts;
   int          rsp_accepts;
   int          mismatches;
   bit          idle_on;
   bit          hold_now;
   bit          row_typed;
   answer_type  row_ans;
   int          hits [4];

   function automatic int unsigned top_prime();
      return primes[prime_cnt - 1];
   endfunction

   function automatic bit is_prime_c(int unsigned c);
      int unsigned k;
      for (k = 0; k < prime_cnt; k++) begin
         if (primes[k] * primes[k] > c) break;
         if (c % primes[k] == 0) return 0;
      end
      return 1;
   endfunction

   function automatic bit append_prime(int unsigned p);
      if (prime_cnt >= TABLE_DEPTH_DEF) return 0;
      primes[prime_cnt] = p;
      prime_cnt++;
      return 1;
   endfunction

   function automatic bit grow_table(int unsigned lim);
      int unsigned c;
      for (c = top_prime() + 1; c <= lim; c++)
         if (is_prime_c(c) && !append_prime(c)) return 0;
      return 1;
   endfunction

   function automatic answer_type next_answer(action_type a, logic [15:0] v);
      answer_type  r;
      int unsigned lo, hi, mid, c;
      bit          found;
      r.prime  = 0;
      r.status = ST_OK;
      case (a)
         ACT_NEXT: begin
            if (v < top_prime()) begin
               lo = 0;
               hi = prime_cnt;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (primes[mid] > v) hi = mid;
                  else lo = mid + 1;
               end
               r.prime = 16'(primes[lo]);
            end else if (!grow_table(v)) begin
               r.status = ST_FULL;
            end else begin
               found = 0;
               for (c = top_prime() + 1; c <= 65535; c++)
                  if (is_prime_c(c)) begin
                     found = 1;
                     break;
                  end
               if (found && append_prime(c)) r.prime = 16'(c);
               else r.status = ST_FULL;
            end
         end
         ACT_READ: begin
            if (v < prime_cnt) r.prime = 16'(primes[v]);
            else r.status = ST_INDEX;
         end
         ACT_EXTEND: begin
            if (!grow_table(v)) r.status = ST_FULL;
            r.prime = 16'(top_prime());
         end
         default: ;
      endcase
      r.count   = 14'(prime_cnt);
      r.largest = 16'(top_prime());
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // request and response monitor
   always @(posedge clock) begin
      answer_type p, e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p = next_answer(action_type'(req_action), req_value);
            if (row_typed) p = row_ans;
            answer_q = {answer_q, p};
            hits[req_action]++;
            req_accepts++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_accepts++;
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response prime=%0d", rsp_prime);
            end else begin
               e = answer_q.pop_front();
               if (rsp_prime !== e.prime || rsp_stored_count !== e.count ||
                   rsp_largest_prime !== e.largest || rsp_status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              e.prime, e.count, e.largest, e.status, rsp_prime,
                              rsp_stored_count, rsp_largest_prime, rsp_status);
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin
      int quiet, last_req, last_rsp;
      quiet = 0;
      last_req = 0;
      last_rsp = 0;
      forever begin
         @(posedge clock);
         if (req_accepts != last_req || rsp_accepts != last_rsp) quiet = 0;
         else quiet++;
         last_req = req_accepts;
         last_rsp = rsp_accepts;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_growing_prime_table_top failed");
            $finish;
         end
      end
   end

   // response side ready
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_now) begin
            rsp_ready = 0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_now = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_ready = 1;
         end
      end
   end

   task automatic send(input action_type a, input logic [15:0] v, input bit typed,
                       input answer_type ans);
      int n0;
      n0 = req_accepts;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid  = 1;
      req_action = a;
      req_value  = v;
      row_typed  = typed;
      row_ans    = ans;
      do @(negedge clock); while (req_accepts == n0);
   endtask

   function automatic row_type mk(action_type a, int v, bit t = 0, int p = 0, int n = 0,
                                  int l = 0, status_type s = ST_OK);
      row_type r;
      r.act = a;
      r.val = 16'(v);
      r.typed = t;
      r.ans.prime = 16'(p);
      r.ans.count = 14'(n);
      r.ans.largest = 16'(l);
      r.ans.status = s;
      return r;
   endfunction

   task automatic drain();
      while (answer_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      row_type     tbl[$];
      answer_type  none;
      int          i, r, top;
      logic [15:0] v;
      action_type  a;

      none = '{default: 0, status: ST_OK};
      req_valid = 0;
      req_action = ACT_NEXT;
      req_value = 0;
      reset = 1;
      idle_on = 1;
      hold_now = 0;
      row_typed = 0;
      row_ans = none;
      req_accepts = 0;
      rsp_accepts = 0;
      mismatches = 0;
      hits = '{default: 0};
      for (i = 0; i < TABLE_DEPTH_DEF; i++) primes[i] = 0;
      primes[0] = 2;
      prime_cnt = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      tbl = '{
         mk(ACT_READ, 0, 1, 2, 1, 2),
         mk(ACT_READ, 1, 1, 0, 1, 2, ST_INDEX),
         mk(ACT_READ, 16'hFFFF, 1, 0, 1, 2, ST_INDEX),
         mk(ACT_NONE, 16'hFFFF, 1, 0, 1, 2),
         mk(ACT_NEXT, 0, 1, 2, 1, 2),
         mk(ACT_NEXT, 1, 1, 2, 1, 2),
         mk(ACT_NEXT, 2, 1, 3, 2, 3),
         mk(ACT_EXTEND, 10, 1, 7, 4, 7),
         mk(ACT_EXTEND, 0, 1, 7, 4, 7),
         mk(ACT_NEXT, 6, 1, 7, 4, 7),
         mk(ACT_NEXT, 7, 1, 11, 5, 11),
         mk(ACT_READ, 4, 1, 11, 5, 11),
         mk(ACT_READ, 5, 1, 0, 5, 11, ST_INDEX),
         mk(ACT_EXTEND, 1000),
         mk(ACT_NEXT, 500),
         mk(ACT_NEXT, 997),
         mk(ACT_READ, 100),
         mk(ACT_NEXT, 1009),
         mk(ACT_NONE, 0),
         mk(ACT_EXTEND, 2000),
         mk(ACT_READ, 16'h2AAA),
         mk(ACT_READ, 16'h5555)
      };
      foreach (tbl[k]) send(tbl[k].act, tbl[k].val, tbl[k].typed, tbl[k].ans);

      // sender pause until every response is back
      req_valid = 0;
      drain();

      for (i = 0; i < 105; i++) begin
         if (i == 30) hold_now = 1;
         if (i == 85) idle_on = 0;
         top = primes[prime_cnt - 1];
         r = $urandom_range(0, 99);
         if (r < 35) begin
            a = ACT_NEXT;
            if ($urandom_range(0, 2) == 0 && top < 4000)
               v = 16'(top + $urandom_range(0, 300));
            else v = 16'($urandom_range(0, top));
         end else if (r < 70) begin
            a = ACT_READ;
            if ($urandom_range(0, 4) == 0) v = 16'($urandom);
            else v = 16'($urandom_range(0, prime_cnt));
         end else if (r < 92) begin
            a = ACT_EXTEND;
            if (top < 4000) v = 16'(top + $urandom_range(0, 400));
            else v = 16'($urandom_range(0, top));
         end else begin
            a = ACT_NONE;
            v = 16'($urandom);
         end
         send(a, v, 0, none);
      end

      // top of the value range, grown in steps
      for (i = 8192; i < 65536; i += 8192) send(ACT_EXTEND, 16'(i), 0, none);
      send(ACT_EXTEND, 16'hFFFF, 0, none);
      send(ACT_NEXT, 16'd65521, 0, none);
      send(ACT_NEXT, 16'hFFFF, 0, none);
      send(ACT_NEXT, 16'd65520, 0, none);
      send(ACT_READ, 16'd6541, 0, none);
      send(ACT_READ, 16'd6542, 0, none);
      send(ACT_READ, 16'hFFFF, 0, none);
      send(ACT_EXTEND, 16'hFFFF, 0, none);
      req_valid = 0;
      drain();
      repeat (100) @(posedge clock);

      $display("%0d requests (next %0d, read %0d, extend %0d, unused %0d), %0d responses",
               req_accepts, hits[0], hits[1], hits[2], hits[3], rsp_accepts);
      $display("table grown to %0d primes, largest %0d", prime_cnt, primes[prime_cnt - 1]);
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("tb_growing_prime_table_top passed");
      end else begin
         $display("tb_growing_prime_table_top failed");
      end
      $finish;
   end
endmodule
